// ----- design/cwts_pkg.sv -----
// ----------------------------------------------------------------------------
// cwts_pkg
// Event and outcome codes shared by the coalescing work-token scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cwts_pkg;

	// event kind carried on the slave tuser
	typedef enum logic [2:0] {
		FN_ACTIVATE   = 3'd0,
		FN_INVALIDATE = 3'd1,
		FN_REQUEST    = 3'd2,
		FN_BEGIN      = 3'd3,
		FN_FINISH     = 3'd4,
		FN_REJECT     = 3'd5
	} func_t;

	localparam int FUNC_BITS = 3;

	// outcome carried on the master tuser
	typedef enum logic [1:0] {
		OC_NONE   = 2'd0,   // refused, stale or inactive
		OC_DONE   = 2'd1,   // done, began, idle or coalesced
		OC_ISSUED = 2'd2    // request accepted or finish rescheduled
	} outcome_t;

	localparam int OUTCOME_BITS = 2;

endpackage

`default_nettype wire

// ----- design/coalescing_work_token_scheduler.sv -----
// ----------------------------------------------------------------------------
// coalescing_work_token_scheduler
// Single-slot work scheduler: activate/invalidate a generation, coalesce
// requests into one pending token, move it to executing and retire it.
// ----------------------------------------------------------------------------
// Usage:
//   s_tuser carries the event kind, s_tdata its generation, token and flags.
//   One result word leaves on m_* for every event: the outcome on m_tuser,
//   the issued token and a snapshot of the state after the event on m_tdata.
//   Path: an accepted word is registered in the input register, decoded
//   against the state and loaded into the result register shown on m_*.
//   Throughput: one event per cycle while m_tready is high; the state
//   update, generation and token checks and token search (at most four
//   candidates) resolve combinationally between input and result registers.
//   Stall: while a result waits on m_tready low, one more event is held in
//   the input register; s_tready drops only when both are occupied.
//   Reset: inactive, generation zero, no pending or executing token, token
//   counter zero; both registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module coalescing_work_token_scheduler import cwts_pkg::*; #(
	parameter int TOKEN_BITS      = 32,
	parameter int GENERATION_BITS = 32,
	localparam int IN_BITS   = GENERATION_BITS + TOKEN_BITS + 2,
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS  = 3 * TOKEN_BITS + GENERATION_BITS + 1,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,

	input  wire logic                    s_tvalid,
	output      logic                    s_tready,
	// generation, token, check_generation, work_remains (low bit first)
	input  wire logic [IN_W-1:0]         s_tdata,
	// func
	input  wire logic [FUNC_BITS-1:0]    s_tuser,

	output      logic                    m_tvalid,
	input  wire logic                    m_tready,
	// issued_token, is_active, current_generation, pending_now, executing_now
	output      logic [OUT_W-1:0]        m_tdata,
	// outcome
	output      logic [OUTCOME_BITS-1:0] m_tuser
);

	localparam int TOK_LO  = GENERATION_BITS;
	localparam int CHK_BIT = GENERATION_BITS + TOKEN_BITS;
	localparam int MOR_BIT = CHK_BIT + 1;

	// input register
	logic                       valid_s1;
	logic [FUNC_BITS-1:0]       fn_s1;
	logic [GENERATION_BITS-1:0] gen_s1;
	logic [TOKEN_BITS-1:0]      tok_s1;
	logic                       chk_s1;
	logic                       more_s1;

	// scheduler state
	logic                       active_q;
	logic [GENERATION_BITS-1:0] gen_q;
	logic [TOKEN_BITS-1:0]      counter_q;
	logic [TOKEN_BITS-1:0]      pend_q;
	logic [TOKEN_BITS-1:0]      exec_q;

	// result register
	logic                       out_valid_q;
	outcome_t                   outcome_q;
	logic [TOKEN_BITS-1:0]      issued_q;

	// next-state values
	logic                       active_d;
	logic [GENERATION_BITS-1:0] gen_d;
	logic [TOKEN_BITS-1:0]      counter_d;
	logic [TOKEN_BITS-1:0]      pend_d;
	logic [TOKEN_BITS-1:0]      exec_d;
	outcome_t                   outcome_d;
	logic [TOKEN_BITS-1:0]      issued_d;

	logic                       adv;
	logic                       gen_ok;
	logic                       tok_ok;
	logic [TOKEN_BITS-1:0]      new_token;
	logic [TOKEN_BITS-1:0]      issue_exec;

	// handshake: the event in s1 moves on when the result register is free
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			fn_s1   <= s_tuser;
			gen_s1  <= s_tdata[GENERATION_BITS-1:0];
			tok_s1  <= s_tdata[TOK_LO +: TOKEN_BITS];
			chk_s1  <= s_tdata[CHK_BIT];
			more_s1 <= s_tdata[MOR_BIT];
		end
	end

	// finish clears the executing slot before the new token is picked
	assign issue_exec = (func_t'(fn_s1) == FN_FINISH) ? '0 : exec_q;

	cwts_token_issue #(
		.TOKEN_BITS (TOKEN_BITS)
	) u_issue (
		.counter    (counter_q),
		.live_a     (pend_q),
		.live_b     (issue_exec),
		.next_token (new_token)
	);

	// generation and token checks
	assign gen_ok = active_q && (gen_s1 != '0) && (gen_s1 == gen_q);
	assign tok_ok = (!chk_s1 || gen_ok) && active_q && (tok_s1 != '0);

	// event decode
	always_comb begin
		active_d  = active_q;
		gen_d     = gen_q;
		counter_d = counter_q;
		pend_d    = pend_q;
		exec_d    = exec_q;
		outcome_d = OC_NONE;
		issued_d  = '0;
		unique case (func_t'(fn_s1))
			FN_ACTIVATE: begin
				if (gen_s1 != '0) begin
					active_d  = 1'b1;
					gen_d     = gen_s1;
					pend_d    = '0;
					exec_d    = '0;
					outcome_d = OC_DONE;
				end
			end
			FN_INVALIDATE: begin
				if (gen_ok) begin
					active_d  = 1'b0;
					gen_d     = '0;
					pend_d    = '0;
					exec_d    = '0;
					outcome_d = OC_DONE;
				end
			end
			FN_REQUEST: begin
				if (gen_ok) begin
					if (pend_q != '0 || exec_q != '0) begin
						outcome_d = OC_DONE;
					end else begin
						counter_d = new_token;
						pend_d    = new_token;
						issued_d  = new_token;
						outcome_d = OC_ISSUED;
					end
				end
			end
			FN_BEGIN: begin
				if (tok_ok && pend_q == tok_s1) begin
					pend_d    = '0;
					exec_d    = tok_s1;
					outcome_d = OC_DONE;
				end
			end
			FN_FINISH: begin
				if (tok_ok && exec_q == tok_s1) begin
					exec_d = '0;
					if (!more_s1) begin
						outcome_d = OC_DONE;
					end else begin
						counter_d = new_token;
						pend_d    = new_token;
						issued_d  = new_token;
						outcome_d = OC_ISSUED;
					end
				end
			end
			FN_REJECT: begin
				if (tok_ok && pend_q == tok_s1) begin
					pend_d    = '0;
					outcome_d = OC_DONE;
				end
			end
			default: begin
				// unused event codes leave everything as it is
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			gen_q       <= '0;
			counter_q   <= '0;
			pend_q      <= '0;
			exec_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				active_q  <= active_d;
				gen_q     <= gen_d;
				counter_q <= counter_d;
				pend_q    <= pend_d;
				exec_q    <= exec_d;
			end
			if (adv)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			outcome_q <= outcome_d;
			issued_q  <= issued_d;
		end
	end

	// state only moves when the result register loads, so it is the snapshot
	assign m_tvalid = out_valid_q;
	assign m_tuser  = outcome_q;
	assign m_tdata  = OUT_W'({exec_q, pend_q, gen_q, active_q, issued_q});

endmodule

`default_nettype wire

// ----- design/cwts_token_issue.sv -----
// ----------------------------------------------------------------------------
// cwts_token_issue
// Picks the next token from the counter: steps past zero and past any token
// that is still live, trying at most four candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module cwts_token_issue #(
	parameter int TOKEN_BITS = 32
) (
	input  wire logic [TOKEN_BITS-1:0] counter,    // last token handed out
	input  wire logic [TOKEN_BITS-1:0] live_a,     // pending token
	input  wire logic [TOKEN_BITS-1:0] live_b,     // executing token
	output      logic [TOKEN_BITS-1:0] next_token
);

	localparam int TRIES = 4;

	logic [TOKEN_BITS-1:0] cand;
	logic                  found;

	// short chain of incrementers, stops at the first free candidate
	always_comb begin
		cand  = counter;
		found = 1'b0;
		for (int i = 0; i < TRIES; i++) begin
			if (!found) begin
				cand = cand + TOKEN_BITS'(1);
				if (cand == '0)
					cand = TOKEN_BITS'(1);
				if (cand != live_a && cand != live_b)
					found = 1'b1;
			end
		end
		next_token = cand;
	end

endmodule

`default_nettype wire
